/* rtl/oist_pkg.sv */
// Package: request and result types, request and status codes for the ordered set table.
package oist_pkg;

  localparam int OIST_CAPACITY = 16;

  localparam logic [2:0] REQ_INSERT     = 3'd0;
  localparam logic [2:0] REQ_DELETE     = 3'd1;
  localparam logic [2:0] REQ_MEMBER     = 3'd2;
  localparam logic [2:0] REQ_COUNT      = 3'd3;
  localparam logic [2:0] REQ_LIST_NEW   = 3'd4;
  localparam logic [2:0] REQ_LIST_OLD   = 3'd5;
  localparam logic [2:0] REQ_CLEAR      = 3'd6;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_ABSENT  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
  } oist_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               found;
    logic [4:0]         occupancy;
    logic signed [31:0] element;
    logic               last;
  } oist_res_t;

endpackage

/* rtl/oist_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module oist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/ordered_integer_set_table_unit.sv */
// Top level: ordered set of distinct 32-bit values held in a RAM, with scan, shift and listing.
//
//   channel  direction  payload     handshake
//   in_      input      oist_req_t  in_valid / in_ready
//   out_     output     oist_res_t  out_valid / out_ready
//
// Insert, delete and member query scan the RAM one entry a cycle; a delete then shifts
// the later entries down by one. Count, clear and no-op go straight to the response.
// A listing reads each held value from the RAM, then loads it to the output.
// Reset clears the count and control only; RAM contents are never read above the count.
// A stalled output holds the sequencer; a new request is taken while the last result waits.
module ordered_integer_set_table_unit
  import oist_pkg::*;
#(
  parameter int CAPACITY = OIST_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  oist_req_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output oist_res_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_SHIFT   = 3'd2;
  localparam logic [2:0] S_LIST_RD = 3'd3;
  localparam logic [2:0] S_LIST_WT = 3'd4;
  localparam logic [2:0] S_RESP    = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [2:0]       req_r, req_nxt;
  logic [31:0]      value_r, value_nxt;
  logic [2:0]       res_status_r, res_status_nxt;
  logic             res_found_r, res_found_nxt;
  logic             out_valid_r, out_valid_nxt;
  oist_res_t        out_data_r, out_data_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      rd_data;

  logic             load_ok;
  logic             hit;
  logic             list_last;

  oist_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load_ok   = !out_valid_r || out_ready;
  assign hit       = pend_r && (rd_data == value_r);
  assign list_last = ((ptr_r + ONE_CNT) == count_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    pend_nxt       = pend_r;
    pend_addr_nxt  = pend_addr_r;
    req_nxt        = req_r;
    value_nxt      = value_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    wr_en          = 1'b0;
    wr_addr        = IDX_W'(count_r);
    wr_data        = value_r;
    rd_en          = 1'b0;
    rd_addr        = IDX_W'(ptr_r);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt        = in_data.req_type;
          value_nxt      = in_data.value;
          ptr_nxt        = '0;
          pend_nxt       = 1'b0;
          res_status_nxt = ST_OK;
          res_found_nxt  = 1'b0;
          case (in_data.req_type)
            REQ_INSERT, REQ_DELETE, REQ_MEMBER: begin
              state_nxt = S_SCAN;
            end
            REQ_LIST_NEW, REQ_LIST_OLD: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                state_nxt = S_LIST_RD;
              end
            end
            REQ_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_RESP;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit || ptr_r >= count_r) begin
          pend_nxt      = 1'b0;
          res_found_nxt = hit;
          state_nxt     = S_RESP;
          case (req_r)
            REQ_INSERT: begin
              if (hit) begin
                res_status_nxt = ST_PRESENT;
              end else if (count_r == CAP_CNT) begin
                res_status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + ONE_CNT;
              end
            end
            REQ_DELETE: begin
              if (hit) begin
                state_nxt = S_SHIFT;
              end else begin
                res_status_nxt = ST_ABSENT;
              end
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end else begin
          rd_en    = 1'b1;
          ptr_nxt  = ptr_r + ONE_CNT;
          pend_nxt = 1'b1;
        end
      end

      S_SHIFT: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr_r;
          wr_data = rd_data;
        end
        if (ptr_r < count_r) begin
          rd_en         = 1'b1;
          pend_addr_nxt = IDX_W'(ptr_r - ONE_CNT);
          ptr_nxt       = ptr_r + ONE_CNT;
          pend_nxt      = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          count_nxt = count_r - ONE_CNT;
          state_nxt = S_RESP;
        end
      end

      S_LIST_RD: begin
        rd_en = 1'b1;
        if (req_r == REQ_LIST_NEW) begin
          rd_addr = IDX_W'(count_r - ONE_CNT - ptr_r);
        end
        state_nxt = S_LIST_WT;
      end

      S_LIST_WT: begin
        if (load_ok) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = ST_OK;
          out_data_nxt.found     = 1'b0;
          out_data_nxt.occupancy = 5'(count_r);
          out_data_nxt.element   = rd_data;
          out_data_nxt.last      = list_last;
          ptr_nxt                = ptr_r + ONE_CNT;
          state_nxt              = list_last ? S_IDLE : S_LIST_RD;
        end
      end

      S_RESP: begin
        if (load_ok) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = res_status_r;
          out_data_nxt.found     = res_found_r;
          out_data_nxt.occupancy = 5'(count_r);
          out_data_nxt.element   = '0;
          out_data_nxt.last      = 1'b1;
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r  <= pend_addr_nxt;
    req_r        <= req_nxt;
    value_r      <= value_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_data_r   <= out_data_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("held count above capacity");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_r)
    else $error("read still pending while idle");

  a_list_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST_WT) |-> (ptr_r < count_r))
    else $error("listing index beyond held count");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (32'(wr_addr) < 32'(CAPACITY)))
    else $error("write beyond table");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) && (state_nxt == S_RESP) |=> (count_r == $past(count_r) - ONE_CNT))
    else $error("delete did not lower count");

endmodule
